### rtl/mpag_pkg.sv
// mpag_pkg: shared types and constants for the memory pressure admission gate
// verdict codes, configuration register indexes and reset values, config struct
// no dependencies
package mpag_pkg;

    localparam int DataW   = 32;
    localparam int MbShift = 20;
    localparam int CfgIdxW = 3;

    // verdict codes carried on the result word
    typedef enum logic [1:0] {
        VERDICT_GRANT     = 2'd0,
        VERDICT_TOO_LARGE = 2'd1,
        VERDICT_REFUSE    = 2'd2,
        VERDICT_BACKOFF   = 2'd3
    } verdict_t;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_MAX_REQUEST      = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_CALIBRATE_FRAMES = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_MARGIN_MB        = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_CEILING_MB       = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_FRUITLESS_LIMIT  = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_PROGRESS_STEP    = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_BACKOFF_LEN      = 3'd6;

    // reset values
    localparam logic [30:0] RST_MAX_REQUEST      = 31'd10485760;
    localparam logic [15:0] RST_CALIBRATE_FRAMES = 16'd300;
    localparam logic [9:0]  RST_MARGIN_MB        = 10'd24;
    localparam logic [11:0] RST_CEILING_MB       = 12'd192;
    localparam logic [7:0]  RST_FRUITLESS_LIMIT  = 8'd8;
    localparam logic [23:0] RST_PROGRESS_STEP    = 24'd262144;
    localparam logic [15:0] RST_BACKOFF_LEN      = 16'd900;

    typedef struct packed {
        logic [30:0] max_request;
        logic [15:0] calibrate_frames;
        logic [9:0]  margin_mb;
        logic [11:0] ceiling_mb;
        logic [7:0]  fruitless_limit;
        logic [23:0] progress_step;
        logic [15:0] backoff_len;
    } cfg_t;

    typedef struct packed {
        verdict_t          verdict;
        logic [DataW-1:0]  budget;
    } judge_res_t;

endpackage

### rtl/memory_pressure_admission_gate_top.sv
// memory_pressure_admission_gate_top: top level of the admission gate
// request register, judge stage and result register; uses mpag_pkg, mpag_cfg, mpag_judge
//
//  channel | dir | handshake           | word
//  --------+-----+---------------------+-------------------------------------------
//  req     | in  | req_valid/req_stall | request_size, heap_used, frame_number
//  rsp     | out | rsp_valid/rsp_stall | granted, verdict, budget_bytes
//  cfg     | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// one word per cycle while rsp is not stalled; rsp_valid comes from the result register
// the gate state loop (budget, progress mark, fruitless count, backoff) closes
// in the judge stage, so each word sees the state left by the last
// reset clears the gate state and loads the default configuration
// a stalled rsp holds its word; the request register keeps taking a word while
// it is empty or while the result register is empty or being drained
module memory_pressure_admission_gate_top (
    input  logic                           clk,
    input  logic                           rst_n,
    // request channel
    input  logic                           req_valid,
    output logic                           req_stall,
    input  logic signed [31:0]             request_size,
    input  logic [31:0]                    heap_used,
    input  logic [31:0]                    frame_number,
    // response channel
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output logic                           granted,
    output logic [1:0]                     verdict,
    output logic [31:0]                    budget_bytes,
    // configuration channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mpag_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [mpag_pkg::DataW-1:0]     cfg_data
);
    import mpag_pkg::*;

    cfg_t       cfg;
    judge_res_t res;

    // request register
    logic             s1_valid_reg;
    logic [DataW-1:0] s1_size_reg;
    logic [DataW-1:0] s1_used_reg;
    logic [DataW-1:0] s1_frame_reg;

    // result register
    logic             rsp_valid_reg,   rsp_valid_next;
    logic             granted_reg;
    verdict_t         verdict_reg;
    logic [DataW-1:0] budget_reg;

    logic advance;
    logic commit;
    logic req_load;

    // result register can take a word when empty or being drained
    assign advance  = !rsp_valid_reg || !rsp_stall;
    assign commit   = s1_valid_reg && advance;
    assign req_stall = s1_valid_reg && !advance;
    assign req_load  = req_valid && !req_stall;

    assign rsp_valid_next = commit || (rsp_valid_reg && rsp_stall);

    mpag_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mpag_judge u_judge (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .commit       (commit),
        .request_size (s1_size_reg),
        .heap_used    (s1_used_reg),
        .frame_number (s1_frame_reg),
        .res          (res)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_load)
                s1_valid_reg <= 1'b1;
            else if (commit)
                s1_valid_reg <= 1'b0;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (req_load)
        begin
            s1_size_reg  <= request_size;
            s1_used_reg  <= heap_used;
            s1_frame_reg <= frame_number;
        end
        if (commit)
        begin
            granted_reg <= (res.verdict == VERDICT_GRANT) || (res.verdict == VERDICT_BACKOFF);
            verdict_reg <= res.verdict;
            budget_reg  <= res.budget;
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign granted      = granted_reg;
    assign verdict      = verdict_reg;
    assign budget_bytes = budget_reg;

    // grant flag must agree with the verdict code
    a_grant_match: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (granted_reg == ((verdict_reg == VERDICT_GRANT)
                                        || (verdict_reg == VERDICT_BACKOFF))))
        else $error("granted disagrees with verdict");

    // a judged word always lands in the result register
    a_commit_lands: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> rsp_valid_reg)
        else $error("committed word not presented");

    // stall on the request side only with a word held and the result blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (s1_valid_reg && rsp_valid_reg && rsp_stall))
        else $error("request stalled without cause");

endmodule

### rtl/mpag_cfg.sv
// mpag_cfg: configuration register file of the admission gate
// depends on mpag_pkg
module mpag_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mpag_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [mpag_pkg::DataW-1:0]     cfg_data,
    output mpag_pkg::cfg_t                 cfg
);
    import mpag_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_request      <= RST_MAX_REQUEST;
            cfg_reg.calibrate_frames <= RST_CALIBRATE_FRAMES;
            cfg_reg.margin_mb        <= RST_MARGIN_MB;
            cfg_reg.ceiling_mb       <= RST_CEILING_MB;
            cfg_reg.fruitless_limit  <= RST_FRUITLESS_LIMIT;
            cfg_reg.progress_step    <= RST_PROGRESS_STEP;
            cfg_reg.backoff_len      <= RST_BACKOFF_LEN;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MAX_REQUEST:      cfg_reg.max_request      <= cfg_data[30:0];
                CFG_CALIBRATE_FRAMES: cfg_reg.calibrate_frames <= cfg_data[15:0];
                CFG_MARGIN_MB:        cfg_reg.margin_mb        <= cfg_data[9:0];
                CFG_CEILING_MB:       cfg_reg.ceiling_mb       <= cfg_data[11:0];
                CFG_FRUITLESS_LIMIT:  cfg_reg.fruitless_limit  <= cfg_data[7:0];
                CFG_PROGRESS_STEP:    cfg_reg.progress_step    <= cfg_data[23:0];
                CFG_BACKOFF_LEN:      cfg_reg.backoff_len      <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

endmodule

### rtl/mpag_judge.sv
// mpag_judge: gate state registers and the combinational admission decision
// depends on mpag_pkg
module mpag_judge (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mpag_pkg::cfg_t                cfg,
    input  logic                          commit,
    input  logic [mpag_pkg::DataW-1:0]    request_size,
    input  logic [mpag_pkg::DataW-1:0]    heap_used,
    input  logic [mpag_pkg::DataW-1:0]    frame_number,
    output mpag_pkg::judge_res_t          res
);
    import mpag_pkg::*;

    logic [DataW-1:0] budget_reg,    budget_next;
    logic [DataW-1:0] mark_reg,      mark_next;
    logic [7:0]       fruitless_reg, fruitless_next;
    logic [DataW-1:0] last_frame_reg, last_frame_next;
    logic [DataW-1:0] backoff_reg,   backoff_next;

    logic             too_large;
    logic             cal_go;
    logic [DataW:0]   cal_sum;
    logic [DataW:0]   cal_cap;
    logic [DataW-1:0] cal_budget;
    logic [DataW:0]   progress_sum;
    logic [7:0]       fruitless_inc;
    verdict_t         verdict;

    assign too_large    = !request_size[DataW-1] && (request_size[30:0] > cfg.max_request);
    assign cal_go       = (budget_reg == '0)
                       && (frame_number >= {16'b0, cfg.calibrate_frames})
                       && (heap_used != '0);
    assign cal_sum      = {1'b0, heap_used} + {3'b0, cfg.margin_mb, {MbShift{1'b0}}};
    assign cal_cap      = {1'b0, cfg.ceiling_mb, {MbShift{1'b0}}};
    assign cal_budget   = (cal_sum > cal_cap) ? cal_cap[DataW-1:0] : cal_sum[DataW-1:0];
    assign progress_sum = {1'b0, heap_used} + {9'b0, cfg.progress_step};
    assign fruitless_inc = fruitless_reg + 8'd1;

    always_comb
    begin
        budget_next     = budget_reg;
        mark_next       = mark_reg;
        fruitless_next  = fruitless_reg;
        last_frame_next = last_frame_reg;
        backoff_next    = backoff_reg;
        verdict         = VERDICT_GRANT;
        if (too_large)
        begin
            verdict = VERDICT_TOO_LARGE;
        end
        else
        begin
            if (cal_go)
                budget_next = cal_budget;
            if (budget_next == '0)
            begin
                verdict = VERDICT_GRANT;
            end
            else if (heap_used <= budget_next)
            begin
                mark_next      = '0;
                fruitless_next = '0;
                verdict        = VERDICT_GRANT;
            end
            else if ((backoff_reg != '0) && (frame_number < backoff_reg))
            begin
                verdict = VERDICT_GRANT;
            end
            else
            begin
                // window over (or none): clear it and judge progress
                backoff_next = '0;
                if ((mark_reg == '0) || (progress_sum < {1'b0, mark_reg}))
                begin
                    mark_next      = heap_used;
                    fruitless_next = '0;
                    verdict        = VERDICT_REFUSE;
                end
                else if (last_frame_reg == frame_number)
                begin
                    verdict = VERDICT_REFUSE;
                end
                else
                begin
                    last_frame_next = frame_number;
                    if (fruitless_inc >= cfg.fruitless_limit)
                    begin
                        fruitless_next = '0;
                        mark_next      = '0;
                        backoff_next   = frame_number + {16'b0, cfg.backoff_len};
                        verdict        = VERDICT_BACKOFF;
                    end
                    else
                    begin
                        fruitless_next = fruitless_inc;
                        verdict        = VERDICT_REFUSE;
                    end
                end
            end
        end
    end

    assign res.verdict = verdict;
    assign res.budget  = budget_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg     <= '0;
            mark_reg       <= '0;
            fruitless_reg  <= '0;
            last_frame_reg <= '0;
            backoff_reg    <= '0;
        end
        else if (commit)
        begin
            budget_reg     <= budget_next;
            mark_reg       <= mark_next;
            fruitless_reg  <= fruitless_next;
            last_frame_reg <= last_frame_next;
            backoff_reg    <= backoff_next;
        end
    end

    // a nonzero calibrated budget is never undone
    a_budget_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (budget_reg != '0) |=> (budget_reg != '0))
        else $error("budget lost after calibration");

    // starting a backoff resets the progress tracking
    a_backoff_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && (verdict == VERDICT_BACKOFF)) |=> ((mark_reg == '0) && (fruitless_reg == '0)))
        else $error("backoff did not clear progress state");

    // an oversized request leaves the gate state alone
    a_too_large_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && too_large) |=> ($stable(budget_reg) && $stable(mark_reg)
                                   && $stable(backoff_reg) && $stable(fruitless_reg)))
        else $error("oversized request changed gate state");

endmodule

### bench/mpag_verdict_check.sv
// mpag_verdict_check: watches the request, response and config channels of the
// admission gate, predicts each response word and compares it field by field
// depends on mpag_pkg for the verdict codes, register indexes and reset values
module mpag_verdict_check (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    input  logic                           req_stall,
    input  logic [31:0]                    request_size,
    input  logic [31:0]                    heap_used,
    input  logic [31:0]                    frame_number,
    input  logic                           rsp_valid,
    input  logic                           rsp_stall,
    input  logic                           granted,
    input  logic [1:0]                     verdict,
    input  logic [31:0]                    budget_bytes,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [mpag_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [mpag_pkg::DataW-1:0]     cfg_data,
    output int                             mismatches,
    output int                             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import mpag_pkg::*;

    typedef struct packed {
        logic        granted;
        verdict_t    verdict;
        logic [31:0] budget;
    } gate_answer_t;

    // register copy and gate state, kept in step with the accepted words
    cfg_t         settings;
    logic [31:0]  budget_q;
    logic [31:0]  mark_q;
    logic [7:0]   fruitless_q;
    logic [31:0]  last_frame_q;
    logic [31:0]  backoff_end_q;
    gate_answer_t answers_q[$];
    int           err_count;

    // decide one request and advance the gate state
    function automatic gate_answer_t judge_request(input logic [31:0] size,
                                                   input logic [31:0] used,
                                                   input logic [31:0] frame);
        gate_answer_t ans;
        verdict_t     v;
        logic [32:0]  wanted;
        logic [32:0]  cap;
        logic [32:0]  reach;
        logic         in_window;
        in_window = 1'b0;
        v = VERDICT_GRANT;
        if (!size[31] && size[30:0] > settings.max_request)
        begin
            v = VERDICT_TOO_LARGE;
        end
        else
        begin
            // calibrates while budget is zero; sum is one bit wider, cannot wrap
            if (budget_q == '0 && frame >= {16'd0, settings.calibrate_frames} && used != '0)
            begin
                wanted = {1'b0, used} + ({23'd0, settings.margin_mb} << MbShift);
                cap = {21'd0, settings.ceiling_mb} << MbShift;
                budget_q = (wanted > cap) ? cap[31:0] : wanted[31:0];
            end
            if (budget_q == '0)
            begin
                v = VERDICT_GRANT;
            end
            else if (used <= budget_q)
            begin
                mark_q = '0;
                fruitless_q = '0;
                v = VERDICT_GRANT;
            end
            else
            begin
                if (backoff_end_q != '0)
                begin
                    if (frame < backoff_end_q)
                        in_window = 1'b1;
                    else
                        backoff_end_q = '0;
                end
                reach = {1'b0, used} + {9'd0, settings.progress_step};
                if (in_window)
                begin
                    v = VERDICT_GRANT;
                end
                else if (mark_q == '0 || reach < {1'b0, mark_q})
                begin
                    mark_q = used;
                    fruitless_q = '0;
                    v = VERDICT_REFUSE;
                end
                else if (last_frame_q == frame)
                begin
                    v = VERDICT_REFUSE;
                end
                else
                begin
                    last_frame_q = frame;
                    fruitless_q = fruitless_q + 8'd1;
                    if (fruitless_q >= settings.fruitless_limit)
                    begin
                        fruitless_q = '0;
                        mark_q = '0;
                        backoff_end_q = frame + {16'd0, settings.backoff_len};
                        v = VERDICT_BACKOFF;
                    end
                    else
                    begin
                        v = VERDICT_REFUSE;
                    end
                end
            end
        end
        ans.granted = (v == VERDICT_GRANT) || (v == VERDICT_BACKOFF);
        ans.verdict = v;
        ans.budget = budget_q;
        return ans;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        gate_answer_t want;
        if (!rst_n)
        begin
            settings.max_request      = RST_MAX_REQUEST;
            settings.calibrate_frames = RST_CALIBRATE_FRAMES;
            settings.margin_mb        = RST_MARGIN_MB;
            settings.ceiling_mb       = RST_CEILING_MB;
            settings.fruitless_limit  = RST_FRUITLESS_LIMIT;
            settings.progress_step    = RST_PROGRESS_STEP;
            settings.backoff_len      = RST_BACKOFF_LEN;
            budget_q = '0;
            mark_q = '0;
            fruitless_q = '0;
            last_frame_q = '0;
            backoff_end_q = '0;
            answers_q.delete();
            err_count = 0;
            mismatches <= 0;
            pending <= 0;
        end
        else
        begin
            // response first, so a stray word is never matched to a new request
            if (rsp_valid && !rsp_stall)
            begin
                if (answers_q.size() == 0)
                begin
                    $display("%0t: response word with nothing outstanding: granted %0b verdict %0d budget %h",
                             $time, granted, verdict, budget_bytes);
                    err_count++;
                end
                else
                begin
                    want = answers_q.pop_front();
                    if (granted !== want.granted)
                    begin
                        $display("%0t: granted expected %0b actual %0b",
                                 $time, want.granted, granted);
                        err_count++;
                    end
                    if (verdict !== want.verdict)
                    begin
                        $display("%0t: verdict expected %0d actual %0d",
                                 $time, want.verdict, verdict);
                        err_count++;
                    end
                    if (budget_bytes !== want.budget)
                    begin
                        $display("%0t: budget_bytes expected %h actual %h",
                                 $time, want.budget, budget_bytes);
                        err_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MAX_REQUEST:      settings.max_request      = cfg_data[30:0];
                    CFG_CALIBRATE_FRAMES: settings.calibrate_frames = cfg_data[15:0];
                    CFG_MARGIN_MB:        settings.margin_mb        = cfg_data[9:0];
                    CFG_CEILING_MB:       settings.ceiling_mb       = cfg_data[11:0];
                    CFG_FRUITLESS_LIMIT:  settings.fruitless_limit  = cfg_data[7:0];
                    CFG_PROGRESS_STEP:    settings.progress_step    = cfg_data[23:0];
                    CFG_BACKOFF_LEN:      settings.backoff_len      = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (req_valid && !req_stall)
                answers_q.push_back(judge_request(request_size, heap_used, frame_number));
            mismatches <= err_count;
            pending <= answers_q.size();
        end
    end

endmodule

### bench/memory_pressure_admission_gate_top_tb.sv
// memory_pressure_admission_gate_top_tb: drives requests and register writes into
// the admission gate, stalls its responses and reports the verdict of the run
// depends on mpag_pkg, memory_pressure_admission_gate_top and mpag_verdict_check
module memory_pressure_admission_gate_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mpag_pkg::*;

    localparam int IdleMax     = 12;    // longest gap or stall per word
    localparam int QuietLimit  = 1000;  // cycles without any handshake
    localparam int DrainCycles = 16;    // settle time after the last response
    localparam int Phases      = 8;
    localparam int RandomItems = 800;

    // index with no register behind it, writes there must be ignored
    localparam logic [CfgIdxW-1:0] CFG_SPARE_INDEX = 3'd7;

    // budget the directed calibration settles on: use of all ones plus
    // 1023 MB wraps 32 bits, so only a wide sum gives the 1024 MB ceiling
    localparam logic [31:0] SettledBudget = 32'h4000_0000;
    localparam logic [11:0] SettleCeiling = 12'd1024;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       req_valid;
    logic                       req_stall;
    logic signed [31:0]         request_size;
    logic [31:0]                heap_used;
    logic [31:0]                frame_number;
    logic                       rsp_valid;
    logic                       rsp_stall;
    logic                       granted;
    logic [1:0]                 verdict;
    logic [31:0]                budget_bytes;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CfgIdxW-1:0]         cfg_index;
    logic [DataW-1:0]           cfg_data;

    int mismatches;
    int pending;

    // run bookkeeping
    bit          idle_on = 1'b0;
    int          quiet_cycles = 0;
    int          requests_sent = 0;
    int          directed_sent = 0;
    int          writes_done = 0;
    int          n_grant = 0;
    int          n_too_large = 0;
    int          n_refuse = 0;
    int          n_backoff = 0;

    // shaping state for the random traffic
    logic [31:0] cur_max;
    logic [31:0] cur_progress;
    logic [31:0] frame_now;
    logic [31:0] heap_now;
    int          burst_left = 0;
    bit          over_budget = 1'b0;

    always #1 clk = ~clk;

    memory_pressure_admission_gate_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .request_size (request_size),
        .heap_used    (heap_used),
        .frame_number (frame_number),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .granted      (granted),
        .verdict      (verdict),
        .budget_bytes (budget_bytes),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    mpag_verdict_check verdict_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .request_size (request_size),
        .heap_used    (heap_used),
        .frame_number (frame_number),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .granted      (granted),
        .verdict      (verdict),
        .budget_bytes (budget_bytes),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    // watchdog and verdict tally, both off the handshakes at the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (rsp_valid && !rsp_stall)
            begin
                case (verdict)
                    VERDICT_GRANT:     n_grant <= n_grant + 1;
                    VERDICT_TOO_LARGE: n_too_large <= n_too_large + 1;
                    VERDICT_REFUSE:    n_refuse <= n_refuse + 1;
                    default:           n_backoff <= n_backoff + 1;
                endcase
            end
            if (quiet_cycles >= QuietLimit)
            begin
                $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // response side: stall a random number of cycles before taking each word
    initial
    begin
        int hold;
        rsp_stall = 1'b0;
        forever
        begin
            hold = idle_on ? $urandom_range(0, IdleMax) : 0;
            if (hold > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            @(posedge clk);
            while (!(rsp_valid && !rsp_stall))
                @(posedge clk);
        end
    end

    // one request word, after a random gap; valid stays up for the next word
    task automatic send_request(input logic [31:0] size, input logic [31:0] used,
                                input logic [31:0] frame);
        int gap;
        gap = idle_on ? $urandom_range(0, IdleMax) : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid    <= 1'b1;
        request_size <= size;
        heap_used    <= used;
        frame_number <= frame;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        requests_sent++;
    endtask

    // stop requesting and wait until every response word is back
    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // random bits above the register width, which the gate must drop
    function automatic logic [31:0] with_junk(input logic [31:0] value, input int width);
        logic [31:0] keep;
        keep = (32'd1 << width) - 32'd1;
        return (value & keep) | ($urandom() & ~keep);
    endfunction

    // valid stays high across back-to-back writes; end_writes lowers it
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        writes_done++;
    endtask

    task automatic end_writes();
        cfg_valid <= 1'b0;
    endtask

    // request size: mostly within the limit, some negative, some at or past it
    function automatic logic [31:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 32'h8000_0000 | $urandom();
        if (r < 14 && cur_max != 32'h7FFF_FFFF)
            return cur_max + 32'd1 + $urandom_range(0, 32'h7FFF_FFFF - cur_max - 32'd1);
        if (r < 18)
            return cur_max;
        return $urandom_range(0, cur_max);
    endfunction

    // new register settings per phase, extremes in rotation
    task automatic configure_phase(input int p);
        logic [31:0] limit;
        logic [31:0] window;
        case (p % 4)
            0:       cur_max = 32'h7FFF_FFFF;
            1:       cur_max = 32'd0;
            2:       cur_max = {1'b0, RST_MAX_REQUEST};
            default: cur_max = $urandom() & 32'h7FFF_FFFF;
        endcase
        case (p % 3)
            0:       cur_progress = 32'd0;
            1:       cur_progress = 32'h00FF_FFFF;
            default: cur_progress = $urandom_range(1, 32'h0010_0000);
        endcase
        case (p % 4)
            0:       limit = $urandom_range(1, 6);
            1:       limit = 32'd0;
            2:       limit = 32'd255;
            default: limit = $urandom_range(2, 12);
        endcase
        case ((p + 1) % 4)
            0:       window = 32'd0;
            1:       window = 32'd1;
            2:       window = $urandom_range(2, 40);
            default: window = 32'h0000_FFFF;
        endcase
        // budget is settled by now, so these three only prove the writes land
        write_reg(CFG_CALIBRATE_FRAMES, with_junk((p % 2 == 0) ? 32'd0 : 32'h0000_FFFF, 16));
        write_reg(CFG_MARGIN_MB, with_junk((p % 2 == 0) ? 32'd1023 : $urandom_range(0, 1023), 10));
        write_reg(CFG_CEILING_MB, with_junk((p % 2 == 1) ? 32'd4095 : $urandom_range(0, 4095), 12));
        write_reg(CFG_MAX_REQUEST, with_junk(cur_max, 31));
        write_reg(CFG_FRUITLESS_LIMIT, with_junk(limit, 8));
        write_reg(CFG_PROGRESS_STEP, with_junk(cur_progress, 24));
        if (p % 3 == 2)
            write_reg(CFG_SPARE_INDEX, $urandom());
        write_reg(CFG_BACKOFF_LEN, with_junk(window, 16));
        end_writes();
    endtask

    // bursts of pressure: heap over budget, falling, flat or rising, frames
    // mostly advancing by one so fruitless counting and backoff get reached
    task automatic run_traffic(input int count);
        int          i;
        int          r;
        logic [31:0] used;
        logic [31:0] step;
        logic [31:0] drop;
        for (i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 12)
            begin
                // noise word, every bit of every field free
                send_request($urandom(), $urandom(), $urandom());
            end
            else
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(4, 30);
                    over_budget = ($urandom_range(0, 9) < 7);
                    // near the top of the range the progress sum carries out
                    if ($urandom_range(0, 4) == 0)
                        heap_now = 32'hFFFF_FFFF - $urandom_range(0, 32'h0000_FFFF);
                    else
                        heap_now = SettledBudget + 32'd1 + $urandom_range(0, 32'hBFFF_FFFE);
                end
                burst_left--;
                r = $urandom_range(0, 99);
                if (r < 20)
                    step = 32'd0;
                else if (r < 95)
                    step = 32'd1;
                else
                    step = $urandom_range(2, 70000);
                frame_now = frame_now + step;
                if (!over_budget)
                begin
                    used = $urandom_range(0, SettledBudget);
                end
                else
                begin
                    r = $urandom_range(0, 99);
                    drop = cur_progress + 32'd1 + $urandom_range(0, 4096);
                    if (r < 30)
                    begin
                        // real progress
                        if (heap_now - drop > SettledBudget)
                            heap_now = heap_now - drop;
                        else
                            heap_now = 32'hFFFF_FFFF - $urandom_range(0, 32'h0000_FFFF);
                    end
                    else if (r < 40)
                    begin
                        // a drop of exactly the progress step is not progress
                        if (heap_now - cur_progress > SettledBudget)
                            heap_now = heap_now - cur_progress;
                    end
                    else if (r >= 75 && r < 90)
                    begin
                        if (heap_now > 32'hFFEF_FFFF)
                            heap_now = 32'hFFFF_FFFF;
                        else
                            heap_now = heap_now + $urandom_range(0, 32'h000F_FFFF);
                    end
                    used = heap_now;
                    // brief dip under budget clears the fruitless run
                    if (r >= 95)
                        used = $urandom_range(0, SettledBudget);
                end
                send_request(pick_size(), used, frame_now);
            end
        end
    endtask

    initial
    begin
        int p;
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        request_size = '0;
        heap_used    = '0;
        frame_number = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_MAX_REQUEST;
        cfg_data     = '0;
        cur_max      = {1'b0, RST_MAX_REQUEST};
        cur_progress = {8'd0, RST_PROGRESS_STEP};
        frame_now    = 32'h0000_0018;
        heap_now     = SettledBudget;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: size limits, uncalibrated grants
        idle_on = 1'b1;
        send_request(32'h7FFF_FFFF, 32'd0, 32'd0);
        send_request(32'h8000_0000, 32'h1234_5678, 32'd100);    // too early to calibrate
        send_request({1'b0, RST_MAX_REQUEST}, 32'd0, 32'd500);  // at the limit, zero use
        send_request({1'b0, RST_MAX_REQUEST} + 32'd1, 32'd1, 32'd0);
        drain();

        // zero ceiling keeps the budget at zero however calibration goes
        write_reg(CFG_CEILING_MB, 32'd0);
        write_reg(CFG_CALIBRATE_FRAMES, 32'd0);
        write_reg(CFG_MAX_REQUEST, 32'h7FFF_FFFF);
        end_writes();
        send_request(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFF, 32'd1, 32'd0);
        drain();

        // zero size limit, calibration held off by frame and by zero use
        write_reg(CFG_MAX_REQUEST, 32'd0);
        write_reg(CFG_CALIBRATE_FRAMES, 32'h0000_FFFF);
        write_reg(CFG_MARGIN_MB, 32'd1023);
        write_reg(CFG_CEILING_MB, 32'd4095);
        end_writes();
        send_request(32'd1, 32'h8000_0000, 32'd0);
        send_request(32'd0, 32'h8000_0000, 32'd65534);
        send_request(32'd0, 32'd0, 32'd65535);
        drain();

        // calibrate with a wrapping sum, then fruitless frames near the top
        // of the frame range so the first backoff end wraps to zero
        write_reg(CFG_MAX_REQUEST, {1'b0, RST_MAX_REQUEST});
        write_reg(CFG_CEILING_MB, {20'd0, SettleCeiling});
        write_reg(CFG_FRUITLESS_LIMIT, 32'd2);
        write_reg(CFG_PROGRESS_STEP, 32'h0010_0000);
        write_reg(CFG_BACKOFF_LEN, 32'h0000_0100);
        end_writes();
        send_request(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FEFE);
        send_request(32'hFFFF_FFFF, 32'hFFEF_FFFF, 32'hFFFF_FEFF);
        send_request(32'd4096, 32'hFFEF_FFFF, 32'hFFFF_FEFF);   // same frame twice
        send_request(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FF00);      // progress sum carries
        send_request(32'hFFFF_FFFB, 32'hF000_0000, 32'hFFFF_FF01);
        send_request(32'd0, 32'hEFEF_FFFF, 32'hFFFF_FF02);
        send_request(32'd0, 32'hEFEF_FFFF, 32'hFFFF_FF03);
        send_request(32'd0, 32'hEFEF_FFFF, 32'hFFFF_FF04);      // window end wraps low
        send_request(32'd0, 32'hEFEF_FFFF, 32'hFFFF_FF05);      // unsigned compare ends it
        send_request(32'd0, SettledBudget, 32'hFFFF_FF06);      // at budget exactly
        drain();

        // zero fruitless limit: the first fruitless frame opens a window
        write_reg(CFG_FRUITLESS_LIMIT, 32'd0);
        write_reg(CFG_BACKOFF_LEN, 32'h0000_0010);
        end_writes();
        send_request(32'd0, 32'h5000_0000, 32'd5);
        send_request(32'd0, 32'h5000_0000, 32'd6);
        send_request(32'd0, 32'h6000_0000, 32'd7);              // inside the window
        send_request(32'd0, 32'h6000_0000, 32'h0000_0016);      // window just over
        drain();

        // zero backoff length: window closes on the next over-budget word
        write_reg(CFG_BACKOFF_LEN, 32'd0);
        end_writes();
        send_request(32'd0, 32'h6000_0000, 32'h0000_0017);
        send_request(32'd0, 32'h6000_0000, 32'h0000_0017);
        directed_sent = requests_sent;

        // random phases, some without any gaps or stalls
        for (p = 0; p < Phases; p++)
        begin
            drain();
            idle_on = (p != 1 && p != 5);
            configure_phase(p);
            run_traffic(RandomItems / Phases);
        end

        drain();
        repeat (DrainCycles) @(posedge clk);

        $display("run: %0d requests (%0d directed), %0d register writes over %0d phases",
                 requests_sent, directed_sent, writes_done, Phases);
        $display("responses: %0d grant, %0d too large, %0d refuse, %0d backoff start",
                 n_grant, n_too_large, n_refuse, n_backoff);
        if (mismatches == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### sim.f
rtl/mpag_pkg.sv
rtl/mpag_cfg.sv
rtl/mpag_judge.sv
rtl/memory_pressure_admission_gate_top.sv
bench/mpag_verdict_check.sv
bench/memory_pressure_admission_gate_top_tb.sv
